// ----- rtl/hat_pkg.sv -----
package hat_pkg;

  // table geometry
  localparam int HANDLE_COUNT = 32;
  localparam int IDX_W        = (HANDLE_COUNT > 2) ? $clog2(HANDLE_COUNT) : 1;
  localparam int CNT_W        = $clog2(HANDLE_COUNT + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 5;
  localparam int TAG_W    = 32;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int CMP_W    = ((IDX_W > HANDLE_W) ? IDX_W : HANDLE_W) + 1;

  // configuration registers
  localparam int                    CFG_ADDR_W  = 3;
  localparam logic                  REG_TIMEOUT = 1'b0;
  localparam logic [TIME_W-1:0]     TIMEOUT_RST = 32'd30000;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_SWEEP  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_FREED     = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_EXPIRED   = 3'd6,
    ST_NONE      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_EXEC  = 2'd2,
    S_FLUSH = 2'd3
  } state_t;

  // free list command
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] push_idx;
  } fifo_cmd_t;

  // entry store write
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
  } ent_wr_t;

  // top index and everything above it are not handles
  function automatic logic hnd_valid(input logic [HANDLE_W-1:0] h);
    return CMP_W'(h) < CMP_W'(HANDLE_COUNT - 1);
  endfunction

endpackage

// ----- rtl/handle_allocator_with_timeout_unit.sv -----
// channel   direction  transaction contents
// in_*      slave      tuser opcode; tdata handle, msg_tag, now
// out_*     master     tuser status; tdata out_handle, out_tag; tlast last
// cfg_*     apb        register 0 timeout_ticks at byte address 0
//
// allocate, free and lookup pass through accept, entry memory read and execute
// sweep does one registered memory read and one age compare per entry,
// each entry through the same read port and compare unit
// rst_n is synchronous; it clears the free list, occupancy and fresh counter
// a full output register holds the sequencer, when it has a result to hand over, until out_tready
module handle_allocator_with_timeout_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // handle[4:0], msg_tag[36:5], now[68:37], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_handle[4:0], out_tag[36:5], zero pad
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [hat_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hat_pkg::*;

  logic [TIME_W-1:0]   timeout_r;
  ent_wr_t             ent_wr;
  logic [IDX_W-1:0]    ent_rd_addr;
  logic [TAG_W-1:0]    ent_rd_tag;
  logic [TIME_W-1:0]   ent_rd_stamp;
  fifo_cmd_t           fifo_cmd;
  logic [IDX_W-1:0]    fifo_head;
  logic                fifo_not_empty;
  status_t             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [TAG_W-1:0]    res_tag;
  logic                cfg_wr;

  // register write on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_TIMEOUT)) begin
      timeout_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TIMEOUT) ? timeout_r : '0;

  hat_entry_mem u_entry_mem (
    .clk      (clk),
    .wr       (ent_wr),
    .rd_addr  (ent_rd_addr),
    .rd_tag   (ent_rd_tag),
    .rd_stamp (ent_rd_stamp)
  );

  hat_free_fifo u_free_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fifo_cmd),
    .head_idx  (fifo_head),
    .not_empty (fifo_not_empty)
  );

  hat_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_op          (op_t'(in_tuser)),
    .in_handle      (in_tdata[4:0]),
    .in_tag         (in_tdata[36:5]),
    .in_now         (in_tdata[68:37]),
    .timeout        (timeout_r),
    .ent_wr         (ent_wr),
    .ent_rd_addr    (ent_rd_addr),
    .ent_rd_tag     (ent_rd_tag),
    .ent_rd_stamp   (ent_rd_stamp),
    .fifo_cmd       (fifo_cmd),
    .fifo_head      (fifo_head),
    .fifo_not_empty (fifo_not_empty),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (res_status),
    .out_handle     (res_handle),
    .out_tag        (res_tag),
    .out_last       (out_tlast)
  );

  // result packing
  assign out_tdata = {3'b000, res_tag, res_handle};
  assign out_tuser = res_status;

endmodule

// ----- rtl/hat_entry_mem.sv -----
module hat_entry_mem (
  input  logic                    clk,
  input  hat_pkg::ent_wr_t        wr,
  input  logic [hat_pkg::IDX_W-1:0]  rd_addr,
  output logic [hat_pkg::TAG_W-1:0]  rd_tag,
  output logic [hat_pkg::TIME_W-1:0] rd_stamp
);
  import hat_pkg::*;

  logic [TAG_W-1:0]  tag_mem   [HANDLE_COUNT];
  logic [TIME_W-1:0] stamp_mem [HANDLE_COUNT];
  logic [TAG_W-1:0]  rd_tag_r;
  logic [TIME_W-1:0] rd_stamp_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_mem[wr.addr]   <= wr.tag;
      stamp_mem[wr.addr] <= wr.stamp;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_tag_r   <= tag_mem[rd_addr];
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  assign rd_tag   = rd_tag_r;
  assign rd_stamp = rd_stamp_r;

endmodule

// ----- rtl/hat_free_fifo.sv -----
module hat_free_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hat_pkg::fifo_cmd_t        cmd,
  output logic [hat_pkg::IDX_W-1:0] head_idx,
  output logic                      not_empty
);
  import hat_pkg::*;

  logic [IDX_W-1:0] fifo_mem [HANDLE_COUNT];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_data_r;
  logic             do_push;
  logic             do_pop;

  assign do_push = cmd.push && (count_r != CNT_W'(HANDLE_COUNT));
  assign do_pop  = cmd.pop && (count_r != '0);

  // pointer wrap at the table size
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt  = (tail_r == IDX_W'(HANDLE_COUNT - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
    if (do_pop) begin
      head_nxt  = (head_r == IDX_W'(HANDLE_COUNT - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // storage, head entry read every cycle
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_mem[tail_r] <= cmd.push_idx;
    end
    head_data_r <= fifo_mem[head_r];
  end

  assign head_idx  = head_data_r;
  assign not_empty = (count_r != '0);

endmodule

// ----- rtl/hat_seq.sv -----
module hat_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  // request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hat_pkg::op_t                 in_op,
  input  logic [hat_pkg::HANDLE_W-1:0] in_handle,
  input  logic [hat_pkg::TAG_W-1:0]    in_tag,
  input  logic [hat_pkg::TIME_W-1:0]   in_now,
  input  logic [hat_pkg::TIME_W-1:0]   timeout,
  // entry store
  output hat_pkg::ent_wr_t             ent_wr,
  output logic [hat_pkg::IDX_W-1:0]    ent_rd_addr,
  input  logic [hat_pkg::TAG_W-1:0]    ent_rd_tag,
  input  logic [hat_pkg::TIME_W-1:0]   ent_rd_stamp,
  // free list
  output hat_pkg::fifo_cmd_t           fifo_cmd,
  input  logic [hat_pkg::IDX_W-1:0]    fifo_head,
  input  logic                         fifo_not_empty,
  // result
  output logic                         out_valid,
  input  logic                         out_ready,
  output hat_pkg::status_t             out_status,
  output logic [hat_pkg::HANDLE_W-1:0] out_handle,
  output logic [hat_pkg::TAG_W-1:0]    out_tag,
  output logic                         out_last
);
  import hat_pkg::*;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [HANDLE_W-1:0] hnd_r;
  logic [TAG_W-1:0]   tag_r;
  logic [TIME_W-1:0]  now_r;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0]   fresh_r, fresh_nxt;
  logic [HANDLE_COUNT-1:0] occ_r, occ_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [TAG_W-1:0]   pend_tag_r, pend_tag_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic               out_last_r;

  logic               accept;
  logic               slot_free;
  logic               h_ok;
  logic [IDX_W-1:0]   hidx;
  logic               expired;
  logic               hit;
  logic               fresh_avail;
  logic               need_emit;
  logic               go;
  logic               scan_done;
  logic               emit;
  status_t            emit_status;
  logic [HANDLE_W-1:0] emit_handle;
  logic [TAG_W-1:0]   emit_tag;
  logic               emit_last;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign h_ok      = hnd_valid(hnd_r);
  assign hidx      = h_ok ? IDX_W'(hnd_r) : '0;

  // shared age compare, modular difference against the timeout
  assign expired     = (now_r - ent_rd_stamp) > timeout;
  assign hit         = occ_r[scan_r] && expired;
  assign fresh_avail = fresh_r < IDX_W'(HANDLE_COUNT - 1);
  assign scan_done   = (scan_r == IDX_W'(HANDLE_COUNT - 2));
  assign ent_rd_addr = (op_r == OP_SWEEP) ? scan_r : hidx;

  // exec waits for the output slot only when it has a result to hand over
  always_comb begin
    need_emit = 1'b0;
    case (state_r)
      S_EXEC:  need_emit = (op_r != OP_SWEEP) || (hit && pend_valid_r);
      S_FLUSH: need_emit = 1'b1;
      default: need_emit = 1'b0;
    endcase
  end
  assign go = slot_free || !need_emit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (go) begin
          if (op_r != OP_SWEEP) state_nxt = S_IDLE;
          else if (scan_done)   state_nxt = S_FLUSH;
          else                  state_nxt = S_READ;
        end
      end
      S_FLUSH: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // actions and result selection
  always_comb begin
    scan_nxt       = scan_r;
    fresh_nxt      = fresh_r;
    occ_nxt        = occ_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_tag_nxt   = pend_tag_r;
    ent_wr         = '0;
    fifo_cmd       = '0;
    emit           = 1'b0;
    emit_status    = ST_NONE;
    emit_handle    = '0;
    emit_tag       = '0;
    emit_last      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_nxt       = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        if (go) begin
          case (op_r)
            OP_ALLOC: begin
              emit = 1'b1;
              if (fresh_avail || fifo_not_empty) begin
                ent_wr.we    = 1'b1;
                ent_wr.addr  = fresh_avail ? fresh_r : fifo_head;
                ent_wr.tag   = tag_r;
                ent_wr.stamp = now_r;
                occ_nxt[ent_wr.addr] = 1'b1;
                if (fresh_avail) fresh_nxt = fresh_r + 1'b1;
                else             fifo_cmd.pop = 1'b1;
                emit_status = ST_ALLOCATED;
                emit_handle = HANDLE_W'(ent_wr.addr);
              end else begin
                emit_status = ST_EXHAUSTED;
              end
            end
            OP_FREE: begin
              emit        = 1'b1;
              emit_handle = hnd_r;
              if (h_ok && occ_r[hidx]) begin
                occ_nxt[hidx]     = 1'b0;
                fifo_cmd.push     = 1'b1;
                fifo_cmd.push_idx = hidx;
                emit_status       = ST_FREED;
              end else begin
                emit_status = ST_IGNORED;
              end
            end
            OP_LOOKUP: begin
              emit        = 1'b1;
              emit_handle = hnd_r;
              if (h_ok && occ_r[hidx] && !expired) begin
                emit_status = ST_FOUND;
                emit_tag    = ent_rd_tag;
              end else begin
                emit_status = ST_NOT_FOUND;
              end
            end
            default: begin
              // sweep: hold one hit back so the final one can carry last
              if (hit) begin
                if (pend_valid_r) begin
                  emit        = 1'b1;
                  emit_status = ST_EXPIRED;
                  emit_handle = HANDLE_W'(pend_idx_r);
                  emit_tag    = pend_tag_r;
                end
                pend_valid_nxt    = 1'b1;
                pend_idx_nxt      = scan_r;
                pend_tag_nxt      = ent_rd_tag;
                occ_nxt[scan_r]   = 1'b0;
                fifo_cmd.push     = 1'b1;
                fifo_cmd.push_idx = scan_r;
              end
              if (!scan_done) scan_nxt = scan_r + 1'b1;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (go) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (pend_valid_r) begin
            emit_status = ST_EXPIRED;
            emit_handle = HANDLE_W'(pend_idx_r);
            emit_tag    = pend_tag_r;
          end
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fresh_r      <= '0;
      occ_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      fresh_r      <= fresh_nxt;
      occ_r        <= occ_nxt;
      pend_valid_r <= pend_valid_nxt;
      scan_r       <= scan_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // transaction fields and held results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      hnd_r <= in_handle;
      tag_r <= in_tag;
      now_r <= in_now;
    end
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_handle_r <= emit_handle;
      out_tag_r    <= emit_tag;
      out_last_r   <= emit_last;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;
  assign out_tag    = out_tag_r;
  assign out_last   = out_last_r;

endmodule
